// ----- rtl/idct_pkg.sv -----
// Shared widths, types and constants of the 8x8 shift-add inverse transform.
package idct_pkg;

   localparam int LANES       = 8;
   localparam int WORD_W      = 16;
   localparam int ACC_W       = 20;
   localparam int PIX_W       = 12;
   localparam int ROUND_SHIFT = 5;
   localparam int ROUND_ADD   = 16;
   localparam int IDX_W       = $clog2(LANES);
   localparam int CNT_W       = $clog2(LANES + 1);

   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(LANES - 1);

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [PIX_W-1:0]  pix_type;

   typedef word_type vec_type [LANES];
   typedef vec_type  mat_type [LANES];
   typedef pix_type  pix_row_type [LANES];
   typedef pix_row_type pix_mat_type [LANES];

endpackage

// ----- rtl/idct_ifs.sv -----
// Valid/ready channel interfaces for coefficient rows and output sample rows.
interface idct_req_if;
   import idct_pkg::*;

   logic     valid;
   logic     ready;
   word_type coef0;
   word_type coef1;
   word_type coef2;
   word_type coef3;
   word_type coef4;
   word_type coef5;
   word_type coef6;
   word_type coef7;

   modport source (
      output valid, coef0, coef1, coef2, coef3, coef4, coef5, coef6, coef7,
      input  ready
   );
   modport sink (
      input  valid, coef0, coef1, coef2, coef3, coef4, coef5, coef6, coef7,
      output ready
   );
endinterface

interface idct_rsp_if;
   import idct_pkg::*;

   logic             valid;
   logic             ready;
   pix_type          pix0;
   pix_type          pix1;
   pix_type          pix2;
   pix_type          pix3;
   pix_type          pix4;
   pix_type          pix5;
   pix_type          pix6;
   pix_type          pix7;
   logic [IDX_W-1:0] out_row;
   logic             row_last;

   modport source (
      output valid, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7, out_row, row_last,
      input  ready
   );
   modport sink (
      input  valid, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7, out_row, row_last,
      output ready
   );
endinterface

// ----- rtl/idct_xform.sv -----
// One 8-point shift-add inverse transform lane, results wrapped to 16 bits.
module idct_xform (
   input  idct_pkg::vec_type x,
   output idct_pkg::vec_type y
);
   import idct_pkg::*;

   acc_type e0, e1, e2, e3, q4, q5, q6, q7;
   acc_type s5, s7;
   acc_type p0, p1, p2, p3, p4, p5, p6, p7;
   acc_type r0, r1, r2, r3, r4, r5, r6, r7;

   always_comb begin
      e0 = ACC_W'(x[0]);
      e1 = ACC_W'(x[4]);
      e2 = ACC_W'(x[2]);
      e3 = ACC_W'(x[6]);
      q4 = ACC_W'(x[1]);
      q5 = ACC_W'(x[5]);
      q6 = ACC_W'(x[3]);
      q7 = ACC_W'(x[7]);

      s5 = q5 + q6;
      s7 = q5 - q6;

      p4 = q4 + s5;
      p5 = q4 - s5;
      p6 = q7 + s7;
      p7 = q7 - s7;

      p0 = e0 + e1;
      p1 = e0 - e1;
      p2 = e2 + (e2 >>> 2) + (e3 >>> 1);
      p3 = (e2 >>> 1) - e3 - (e3 >>> 2);

      r4 = (p7 >>> 2) + p4 + (p4 >>> 2) - (p4 >>> 4);
      r7 = (p4 >>> 2) - p7 - (p7 >>> 2) + (p7 >>> 4);
      r5 = p5 - p6 + (p6 >>> 2) + (p6 >>> 4);
      r6 = p6 + p5 - (p5 >>> 2) - (p5 >>> 4);

      r0 = p0 + p2;
      r1 = p1 + p3;
      r2 = p1 - p3;
      r3 = p0 - p2;

      y[0] = WORD_W'(r0 + r4);
      y[1] = WORD_W'(r1 + r5);
      y[2] = WORD_W'(r2 + r6);
      y[3] = WORD_W'(r3 + r7);
      y[4] = WORD_W'(r3 - r7);
      y[5] = WORD_W'(r2 - r6);
      y[6] = WORD_W'(r1 - r5);
      y[7] = WORD_W'(r0 - r4);
   end

endmodule

// ----- rtl/idct_cols.sv -----
// Eight column lanes in parallel and the result row buffer that merges their outputs.
module idct_cols (
   input  logic                clock,
   input  logic                reset,
   input  idct_pkg::mat_type   tb,
   input  logic                load,
   output logic                busy,
   idct_rsp_if.source          rsp
);
   import idct_pkg::*;

   mat_type          col_y;
   pix_mat_type      res_ff;
   pix_mat_type      res_in;
   logic [CNT_W-1:0] rows_left_ff;
   logic [CNT_W-1:0] rows_left_in;
   logic [IDX_W-1:0] row_idx_ff;
   logic [IDX_W-1:0] row_idx_in;
   logic             take;

   function automatic pix_type round_pix(input word_type v);
      logic signed [WORD_W:0] t;
      t = (WORD_W + 1)'(v) + (WORD_W + 1)'(ROUND_ADD);
      return t[WORD_W:ROUND_SHIFT];
   endfunction

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      idct_xform u_lane (
         .x(tb[i]),
         .y(col_y[i])
      );
   end

   assign take = rsp.valid && rsp.ready;

   always_comb begin
      res_in       = res_ff;
      rows_left_in = rows_left_ff;
      row_idx_in   = row_idx_ff;
      if (load) begin
         for (int k = 0; k < LANES; k++) begin
            for (int i = 0; i < LANES; i++) begin
               res_in[k][i] = round_pix(col_y[i][k]);
            end
         end
         rows_left_in = CNT_W'(LANES);
         row_idx_in   = '0;
      end else if (take) begin
         for (int k = 0; k < LANES - 1; k++) begin
            res_in[k] = res_ff[k + 1];
         end
         rows_left_in = rows_left_ff - CNT_W'(1);
         row_idx_in   = row_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         rows_left_ff <= '0;
         row_idx_ff   <= '0;
      end else begin
         rows_left_ff <= rows_left_in;
         row_idx_ff   <= row_idx_in;
      end
   end

   assign busy         = rows_left_ff != '0;
   assign rsp.valid    = busy;
   assign rsp.pix0     = res_ff[0][0];
   assign rsp.pix1     = res_ff[0][1];
   assign rsp.pix2     = res_ff[0][2];
   assign rsp.pix3     = res_ff[0][3];
   assign rsp.pix4     = res_ff[0][4];
   assign rsp.pix5     = res_ff[0][5];
   assign rsp.pix6     = res_ff[0][6];
   assign rsp.pix7     = res_ff[0][7];
   assign rsp.out_row  = row_idx_ff;
   assign rsp.row_last = row_idx_ff == LAST_ROW;

endmodule

// ----- rtl/idct8x8_shift_add.sv -----
// Top level of the 8x8 shift-add inverse transform.
// Coefficient rows are taken one per cycle while req_ch.ready is high. Each row is registered, passed
// through the row lane and written as one column of the transpose buffer on the next cycle. In
// the cycle after the eighth row is written, eight column lanes transform all buffer rows at once
// and load the rounded results into the output row buffer. The first result row of a block is
// offered once that buffer is loaded, and the rows then leave one per cycle while the sink is ready. The
// first seven rows of the next block are taken while results drain; its eighth row waits until the
// output row buffer is empty. Only the low COEF_BITS bits of each coefficient are used, as a signed
// value.
module idct8x8_shift_add #(
   parameter int COEF_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   idct_req_if.sink   req_ch,
   idct_rsp_if.source rsp_ch
);
   import idct_pkg::*;

   typedef logic [WORD_W-1:0] raw_type [LANES];

   raw_type          raw;
   logic             accept;
   logic             busy;
   logic             in_vld_ff;
   logic             in_vld_in;
   vec_type          in_row_ff;
   vec_type          in_row_in;
   logic [IDX_W-1:0] wr_col_ff;
   logic [IDX_W-1:0] wr_col_in;
   logic [IDX_W-1:0] acc_cnt_ff;
   logic [IDX_W-1:0] acc_cnt_in;
   logic             go_ff;
   logic             go_in;
   mat_type          tb_ff;
   mat_type          tb_in;
   vec_type          row_y;

   assign raw[0] = req_ch.coef0;
   assign raw[1] = req_ch.coef1;
   assign raw[2] = req_ch.coef2;
   assign raw[3] = req_ch.coef3;
   assign raw[4] = req_ch.coef4;
   assign raw[5] = req_ch.coef5;
   assign raw[6] = req_ch.coef6;
   assign raw[7] = req_ch.coef7;

   assign req_ch.ready = (acc_cnt_ff != LAST_ROW) || !busy;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_row_in  = in_row_ff;
      wr_col_in  = wr_col_ff;
      acc_cnt_in = acc_cnt_ff;
      in_vld_in  = accept;
      if (accept) begin
         for (int i = 0; i < LANES; i++) begin
            in_row_in[i] = WORD_W'(signed'(raw[i][COEF_BITS-1:0]));
         end
         wr_col_in  = acc_cnt_ff;
         acc_cnt_in = acc_cnt_ff + IDX_W'(1);
      end
   end

   idct_xform u_row (
      .x(in_row_ff),
      .y(row_y)
   );

   always_comb begin
      tb_in = tb_ff;
      if (in_vld_ff) begin
         for (int k = 0; k < LANES; k++) begin
            tb_in[k][wr_col_ff] = row_y[k];
         end
      end
      go_in = in_vld_ff && (wr_col_ff == LAST_ROW);
   end

   always_ff @(posedge clock) begin
      in_row_ff <= in_row_in;
      wr_col_ff <= wr_col_in;
      tb_ff     <= tb_in;
      if (reset) begin
         in_vld_ff  <= 1'b0;
         acc_cnt_ff <= '0;
         go_ff      <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         acc_cnt_ff <= acc_cnt_in;
         go_ff      <= go_in;
      end
   end

   idct_cols u_cols (
      .clock(clock),
      .reset(reset),
      .tb(tb_ff),
      .load(go_ff),
      .busy(busy),
      .rsp(rsp_ch)
   );

endmodule

// ----- rtl/idct_checker.sv -----
// Port-level assertions on the result channel of the transform, bound to the top level.
module idct_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [idct_pkg::IDX_W-1:0] rsp_out_row,
   input logic                       rsp_row_last
);
   import idct_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item withdrawn before it was taken.");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_last == (rsp_out_row == LAST_ROW)))
      else $error("Last-row flag disagrees with the row index.");

   a_row_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_row_last |=>
         rsp_valid && (rsp_out_row == IDX_W'($past(rsp_out_row) + IDX_W'(1))))
      else $error("Result rows of a block did not follow in order.");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_row_last |=> !rsp_valid || (rsp_out_row == '0))
      else $error("A new block did not start at row zero.");

endmodule

bind idct8x8_shift_add idct_checker u_chk (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_out_row(rsp_ch.out_row),
   .rsp_row_last(rsp_ch.row_last)
);
